/* design/pshm_pkg.sv */
// Shared constants, types and codes for the pair sum hash matcher.
`timescale 1ns / 1ps

package pshm_pkg;

    // Table geometry and element numbering
    localparam int TableBits = 10;
    localparam int TableSize = 1 << TableBits;
    localparam int MaxItems  = 65536;
    localparam int CountW    = $clog2(MaxItems + 1);
    localparam int IndexW    = 16;
    localparam int ValueW    = 32;
    localparam int EpochW    = 8;

    // Multiplicative hash constant (golden ratio, 32 bits)
    localparam logic [ValueW-1:0] HashMul = 32'h9E37_79B1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_IGNORED  = 2'd2,
        STATUS_OVERFLOW = 2'd3
    } status_t;

    // One table slot: epoch tag, stored key, stored element index
    typedef struct packed {
        logic [EpochW-1:0] epoch;
        logic [ValueW-1:0] key;
        logic [IndexW-1:0] index;
    } entry_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_RESET_SWEEP,
        ST_IDLE,
        ST_START,
        ST_ARRAY_SWEEP,
        ST_CLASSIFY,
        ST_HASH_C,
        ST_PSTART_C,
        ST_PROBE_C,
        ST_HASH_V,
        ST_PSTART_V,
        ST_PROBE_V,
        ST_OUTPUT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    in_ready;
        logic    sweep;
        logic    sweep_done;
        logic    new_array;
        logic    classify;
        logic    set_status;
        status_t status_code;
        logic    hash;
        logic    probe_start;
        logic    probe_step;
        logic    sel_value;
        logic    found;
        logic    insert;
        logic    push;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic in_valid;
        logic first;
        logic epoch_max;
        logic sweep_last;
        logic matched;
        logic overflow;
        logic comp_ok;
        logic slot_hit;
        logic slot_stop;
        logic probe_last;
        logic out_free;
    } stat_t;

endpackage

/* design/pshm_ctrl.sv */
// Controller state machine: sequences sweep, hashing, probing and result hand-off.
`timescale 1ns / 1ps

module pshm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  pshm_pkg::stat_t stat,
    output pshm_pkg::cmd_t  cmd
);

    pshm_pkg::state_t state_reg;
    pshm_pkg::state_t state_next;

    // State register; reset starts with a sweep of the table tags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pshm_pkg::ST_RESET_SWEEP;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.status_code = pshm_pkg::STATUS_OK;
        case (state_reg)
            pshm_pkg::ST_RESET_SWEEP: begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last) begin
                    cmd.sweep_done = 1'b1;
                    state_next     = pshm_pkg::ST_IDLE;
                end
            end
            pshm_pkg::ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid) begin
                    state_next = pshm_pkg::ST_START;
                end
            end
            pshm_pkg::ST_START: begin
                if (stat.first && stat.epoch_max) begin
                    state_next = pshm_pkg::ST_ARRAY_SWEEP;
                end else begin
                    cmd.new_array = stat.first;
                    state_next    = pshm_pkg::ST_CLASSIFY;
                end
            end
            pshm_pkg::ST_ARRAY_SWEEP: begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last) begin
                    cmd.sweep_done = 1'b1;
                    state_next     = pshm_pkg::ST_CLASSIFY;
                end
            end
            pshm_pkg::ST_CLASSIFY: begin
                cmd.classify = 1'b1;
                if (stat.matched) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = pshm_pkg::STATUS_IGNORED;
                    state_next      = pshm_pkg::ST_OUTPUT;
                end else if (stat.overflow) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = pshm_pkg::STATUS_OVERFLOW;
                    state_next      = pshm_pkg::ST_OUTPUT;
                end else if (stat.comp_ok) begin
                    state_next = pshm_pkg::ST_HASH_C;
                end else begin
                    state_next = pshm_pkg::ST_HASH_V;
                end
            end
            pshm_pkg::ST_HASH_C: begin
                cmd.hash   = 1'b1;
                state_next = pshm_pkg::ST_PSTART_C;
            end
            pshm_pkg::ST_PSTART_C: begin
                cmd.probe_start = 1'b1;
                state_next      = pshm_pkg::ST_PROBE_C;
            end
            pshm_pkg::ST_PROBE_C: begin
                if (stat.slot_hit) begin
                    cmd.found  = 1'b1;
                    state_next = pshm_pkg::ST_OUTPUT;
                end else if (stat.slot_stop || stat.probe_last) begin
                    cmd.sel_value = 1'b1;
                    state_next    = pshm_pkg::ST_HASH_V;
                end else begin
                    cmd.probe_step = 1'b1;
                end
            end
            pshm_pkg::ST_HASH_V: begin
                cmd.hash   = 1'b1;
                state_next = pshm_pkg::ST_PSTART_V;
            end
            pshm_pkg::ST_PSTART_V: begin
                cmd.probe_start = 1'b1;
                state_next      = pshm_pkg::ST_PROBE_V;
            end
            pshm_pkg::ST_PROBE_V: begin
                if (stat.slot_stop) begin
                    cmd.insert = 1'b1;
                    state_next = pshm_pkg::ST_OUTPUT;
                end else if (stat.probe_last) begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = pshm_pkg::STATUS_FULL;
                    state_next      = pshm_pkg::ST_OUTPUT;
                end else begin
                    cmd.probe_step = 1'b1;
                end
            end
            pshm_pkg::ST_OUTPUT: begin
                if (stat.out_free) begin
                    cmd.push   = 1'b1;
                    state_next = pshm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pshm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* design/pshm_datapath.sv */
// Datapath: slot memory, hash unit, probe address logic, counters and output register.
`timescale 1ns / 1ps

module pshm_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pshm_pkg::ValueW-1:0]   cfg_wr_data,
    input  logic                          s_tvalid,
    input  logic [pshm_pkg::ValueW-1:0]   s_tdata,
    input  logic [0:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,
    input  pshm_pkg::cmd_t                cmd,
    output pshm_pkg::stat_t               stat
);

    localparam int TB = pshm_pkg::TableBits;

    // Slot memory, one read and one write port
    pshm_pkg::entry_t slot_mem [pshm_pkg::TableSize];
    pshm_pkg::entry_t rd_reg;
    logic [TB-1:0]    rd_addr;
    logic             wr_en;
    logic [TB-1:0]    wr_addr;
    pshm_pkg::entry_t wr_data;

    // Item and configuration
    logic [pshm_pkg::ValueW-1:0] target_reg;
    logic [pshm_pkg::ValueW-1:0] value_reg;
    logic                        first_reg;
    logic [pshm_pkg::ValueW-1:0] key_reg;
    logic [pshm_pkg::ValueW-1:0] mul_reg;
    logic [pshm_pkg::ValueW-1:0] prod;
    logic [pshm_pkg::ValueW-1:0] mix;
    logic [TB-1:0]               hash_slot;
    logic [pshm_pkg::ValueW:0]   comp;
    logic                        comp_ok;

    // Probe and sweep
    logic [TB-1:0] probe_addr_reg;
    logic [TB-1:0] probe_cnt_reg;
    logic [TB-1:0] sweep_addr_reg;

    // Array state
    logic [pshm_pkg::EpochW-1:0] epoch_reg;
    logic [pshm_pkg::CountW-1:0] count_reg;
    logic                        matched_reg;
    logic                        overflow;
    logic [pshm_pkg::IndexW-1:0] idx_reg;

    // Result staging and output register
    logic                        res_found_reg;
    logic [pshm_pkg::IndexW-1:0] res_earlier_reg;
    logic [pshm_pkg::IndexW-1:0] res_current_reg;
    pshm_pkg::status_t           res_status_reg;
    logic                        m_valid_reg;
    logic [39:0]                 m_data_reg;
    logic                        slot_valid;
    logic                        key_eq;

    // Complement at 33 bits; fits when the top two bits agree
    assign comp    = {target_reg[pshm_pkg::ValueW-1], target_reg}
                   - {value_reg[pshm_pkg::ValueW-1], value_reg};
    assign comp_ok = (comp[pshm_pkg::ValueW] == comp[pshm_pkg::ValueW-1]);

    // Hash: registered low-half multiply, then fold the upper half into the slot bits
    assign prod      = key_reg * pshm_pkg::HashMul;
    assign mix       = mul_reg ^ (mul_reg >> 16);
    assign hash_slot = mix[TB-1:0];

    // Slot compare against the current epoch
    assign slot_valid = (rd_reg.epoch == epoch_reg);
    assign key_eq     = (rd_reg.key == key_reg);

    assign overflow = (count_reg >= pshm_pkg::CountW'(pshm_pkg::MaxItems))
                   || (count_reg > pshm_pkg::CountW'(65535));

    // Memory port selection
    always_comb begin
        if (cmd.probe_start) begin
            rd_addr = hash_slot;
        end else if (cmd.probe_step) begin
            rd_addr = probe_addr_reg + TB'(1);
        end else begin
            rd_addr = probe_addr_reg;
        end
        wr_en = cmd.sweep || cmd.insert;
        if (cmd.sweep) begin
            wr_addr       = sweep_addr_reg;
            wr_data.epoch = '0;
            wr_data.key   = '0;
            wr_data.index = '0;
        end else begin
            wr_addr       = probe_addr_reg;
            wr_data.epoch = epoch_reg;
            wr_data.key   = key_reg;
            wr_data.index = idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg <= slot_mem[rd_addr];
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
        end else if (cfg_wr_en) begin
            target_reg <= cfg_wr_data;
        end
    end

    // Input beat capture, key selection and hashing
    always_ff @(posedge aclk) begin
        if (s_tvalid && cmd.in_ready) begin
            value_reg <= s_tdata;
            first_reg <= s_tuser[0];
        end
        if (cmd.classify) begin
            key_reg <= comp_ok ? comp[pshm_pkg::ValueW-1:0] : value_reg;
        end else if (cmd.sel_value) begin
            key_reg <= value_reg;
        end
        if (cmd.hash) begin
            mul_reg <= prod;
        end
    end

    // Probe and sweep counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_addr_reg <= '0;
            probe_cnt_reg  <= '0;
            sweep_addr_reg <= '0;
        end else begin
            if (cmd.probe_start) begin
                probe_addr_reg <= hash_slot;
                probe_cnt_reg  <= '0;
            end else if (cmd.probe_step) begin
                probe_addr_reg <= probe_addr_reg + TB'(1);
                probe_cnt_reg  <= probe_cnt_reg + TB'(1);
            end
            if (cmd.sweep) begin
                sweep_addr_reg <= sweep_addr_reg + TB'(1);
            end
        end
    end

    // Epoch, element count and match flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            epoch_reg   <= pshm_pkg::EpochW'(1);
            count_reg   <= '0;
            matched_reg <= 1'b0;
        end else begin
            if (cmd.sweep_done) begin
                epoch_reg   <= pshm_pkg::EpochW'(1);
                count_reg   <= '0;
                matched_reg <= 1'b0;
            end else if (cmd.new_array) begin
                epoch_reg   <= epoch_reg + pshm_pkg::EpochW'(1);
                count_reg   <= '0;
                matched_reg <= 1'b0;
            end else begin
                if (cmd.classify
                    && count_reg < pshm_pkg::CountW'(pshm_pkg::MaxItems)) begin
                    count_reg <= count_reg + pshm_pkg::CountW'(1);
                end
                if (cmd.found) begin
                    matched_reg <= 1'b1;
                end
            end
        end
    end

    // Result staging
    always_ff @(posedge aclk) begin
        if (cmd.classify) begin
            idx_reg         <= count_reg[pshm_pkg::IndexW-1:0];
            res_found_reg   <= 1'b0;
            res_earlier_reg <= '0;
            res_current_reg <= (count_reg > pshm_pkg::CountW'(65535))
                             ? '1 : count_reg[pshm_pkg::IndexW-1:0];
        end
        if (cmd.classify || cmd.set_status) begin
            res_status_reg <= cmd.set_status ? cmd.status_code : pshm_pkg::STATUS_OK;
        end
        if (cmd.found) begin
            res_found_reg   <= 1'b1;
            res_earlier_reg <= rd_reg.index;
        end
    end

    // Output register: a finished beat waits here while the next item runs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_data_reg <= {5'd0, res_status_reg, res_current_reg,
                           res_earlier_reg, res_found_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Status to the controller
    always_comb begin
        stat.in_valid   = s_tvalid;
        stat.first      = first_reg;
        stat.epoch_max  = (epoch_reg == '1);
        stat.sweep_last = (sweep_addr_reg == '1);
        stat.matched    = matched_reg;
        stat.overflow   = overflow;
        stat.comp_ok    = comp_ok;
        stat.slot_hit   = slot_valid && key_eq;
        stat.slot_stop  = !slot_valid || key_eq;
        stat.probe_last = (probe_cnt_reg == '1);
        stat.out_free   = !m_valid_reg || m_tready;
    end

    // A result is only loaded when the output register can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (!m_valid_reg || m_tready))
        else $error("result pushed over an untaken beat");

    // A found pair always reports status ok
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[0])
            |-> (m_data_reg[34:33] == pshm_pkg::STATUS_OK))
        else $error("pair reported with non-ok status");

    // Epoch zero marks swept slots and is never live
    assert property (@(posedge aclk) disable iff (!aresetn)
        epoch_reg != '0)
        else $error("epoch reached the swept tag");

    // Finding a pair sets the match flag for the rest of the array
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.found |=> matched_reg)
        else $error("match flag not set after a pair");

endmodule

/* design/pair_sum_hash_matcher_unit.sv */
// Top level of the pair sum hash matcher: controller and datapath.
`timescale 1ns / 1ps

// Streaming two-sum matcher. Each input beat carries one signed 32-bit element;
// s_tuser marks the first element of a new array. Every beat gives exactly one
// result beat: pair flag, earlier index, current index and status. The user must
// write target_sum through cfg_wr_en/cfg_wr_data only while the block is idle;
// the block itself does not enforce this. The table is a 1024-slot open-addressed
// hash memory probed one slot per cycle over its single read port; a lookup runs
// until it hits its key, finds a free slot or has probed every slot. After reset
// the block sweeps the slot tags before it takes its first beat; the same sweep
// runs at the start of every 255th array, when the epoch tag that marks live slots
// wraps.
module pair_sum_hash_matcher_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] element_value
    input  logic [0:0]  s_tuser,   // [0] first_of_array
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [0] pair_found, [16:1] earlier_index,
                                   // [32:17] current_index, [34:33] status, rest 0
);

    pshm_pkg::cmd_t  cmd;
    pshm_pkg::stat_t stat;

    // Sequencing
    pshm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Table, hash and result path
    pshm_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .stat        (stat)
    );

    assign s_tready = cmd.in_ready;

endmodule

/* tb/pshm_checker.sv */
// Watches the pair sum hash matcher channels, predicts every result beat and compares it.
`timescale 1ns / 1ps

module pshm_match_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          pending,
    output int          fail_count
);

    // One predicted result beat
    typedef struct {
        logic                        pair_found;
        logic [pshm_pkg::IndexW-1:0] earlier_index;
        logic [pshm_pkg::IndexW-1:0] current_index;
        pshm_pkg::status_t           status;
    } pair_result_t;

    // Shadow of the hash table and per-array bookkeeping
    logic [pshm_pkg::ValueW-1:0] shadow_key   [pshm_pkg::TableSize];
    logic [pshm_pkg::IndexW-1:0] shadow_index [pshm_pkg::TableSize];
    bit                          shadow_used  [pshm_pkg::TableSize];
    int                          elem_count;
    bit                          array_matched;
    logic [pshm_pkg::ValueW-1:0] target_sum;
    pair_result_t                expected_pairs[$];

    // Start of a new array: all slots free, numbering from zero
    function automatic void clear_array();
        foreach (shadow_used[i]) shadow_used[i] = 1'b0;
        elem_count    = 0;
        array_matched = 1'b0;
    endfunction

    // Multiplicative hash, folded, reduced to a home slot
    function automatic int home_slot(logic [pshm_pkg::ValueW-1:0] key);
        logic [31:0] h;
        h = key * pshm_pkg::HashMul;
        h = h ^ (h >> 16);
        return int'(h % 32'(pshm_pkg::TableSize));
    endfunction

    // Linear probe: slot holding key, else first free slot; TableSize if full and absent
    function automatic int find_slot(logic [pshm_pkg::ValueW-1:0] key);
        int s;
        s = home_slot(key);
        for (int n = 0; n < pshm_pkg::TableSize; n++) begin
            if (!shadow_used[s] || shadow_key[s] == key)
                return s;
            s = (s + 1) % pshm_pkg::TableSize;
        end
        return pshm_pkg::TableSize;
    endfunction

    // Expected result for one accepted element; updates the shadow state
    function automatic pair_result_t predict_pair(logic [pshm_pkg::ValueW-1:0] value,
                                                  logic first);
        pair_result_t r;
        int           idx;
        int           s;
        longint       comp;
        if (first)
            clear_array();
        idx = elem_count;
        if (elem_count < pshm_pkg::MaxItems)
            elem_count++;
        r.pair_found    = 1'b0;
        r.earlier_index = '0;
        r.current_index = (idx > 65535) ? 16'hFFFF : idx[15:0];
        r.status        = pshm_pkg::STATUS_OK;
        // ignored after a match takes priority over overflow
        if (array_matched) begin
            r.status = pshm_pkg::STATUS_IGNORED;
            return r;
        end
        if (idx >= pshm_pkg::MaxItems || idx > 65535) begin
            r.status = pshm_pkg::STATUS_OVERFLOW;
            return r;
        end
        // complement outside 32-bit signed range can never hit
        comp = longint'($signed(target_sum)) - longint'($signed(value));
        if (comp >= -(64'sd1 <<< 31) && comp < (64'sd1 <<< 31)) begin
            s = find_slot(comp[31:0]);
            if (s < pshm_pkg::TableSize && shadow_used[s]) begin
                r.pair_found    = 1'b1;
                r.earlier_index = shadow_index[s];
                array_matched   = 1'b1;
                return r;
            end
        end
        // miss: insert, or overwrite the index of a duplicate value
        s = find_slot(value);
        if (s >= pshm_pkg::TableSize) begin
            r.status = pshm_pkg::STATUS_FULL;
            return r;
        end
        if (!shadow_used[s]) begin
            shadow_used[s] = 1'b1;
            shadow_key[s]  = value;
        end
        shadow_index[s] = idx[15:0];
        return r;
    endfunction

    // Sample both channels and the register port at each rising edge
    always @(posedge aclk) begin : monitor
        pair_result_t exp_r;
        bit           mismatch;
        if (!aresetn) begin
            clear_array();
            target_sum = '0;
            expected_pairs.delete();
        end else begin
            if (cfg_wr_en)
                target_sum = cfg_wr_data;
            if (s_tvalid && s_tready)
                expected_pairs.insert(expected_pairs.size(),
                                      predict_pair(s_tdata, s_tuser[0]));
            if (m_tvalid && m_tready) begin
                if (expected_pairs.size() == 0) begin
                    $error("result beat with no element outstanding: m_tdata=%h", m_tdata);
                    fail_count++;
                end else begin
                    exp_r    = expected_pairs.pop_front();
                    mismatch = 1'b0;
                    if (m_tdata[0] !== exp_r.pair_found) begin
                        $error("pair_found: expected %0d, got %0d",
                               exp_r.pair_found, m_tdata[0]);
                        mismatch = 1'b1;
                    end
                    if (m_tdata[16:1] !== exp_r.earlier_index) begin
                        $error("earlier_index: expected %0d, got %0d",
                               exp_r.earlier_index, m_tdata[16:1]);
                        mismatch = 1'b1;
                    end
                    if (m_tdata[32:17] !== exp_r.current_index) begin
                        $error("current_index: expected %0d, got %0d",
                               exp_r.current_index, m_tdata[32:17]);
                        mismatch = 1'b1;
                    end
                    if (m_tdata[34:33] !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, m_tdata[34:33]);
                        mismatch = 1'b1;
                    end
                    if (mismatch)
                        fail_count++;
                end
            end
        end
        pending = expected_pairs.size();
    end

endmodule

/* tb/pair_sum_hash_matcher_unit_tb.sv */
// Stimulus and verdict for the pair sum hash matcher; checking sits in pshm_match_checker.
`timescale 1ns / 1ps

module pair_sum_hash_matcher_unit_tb;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [31:0] element_value
    logic [0:0]  s_tuser;    // [0] first_of_array
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // [0] pair_found, [16:1] earlier_index,
                             // [32:17] current_index, [34:33] status
    int          pending;
    int          fail_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic [31:0] cur_target;

    pair_sum_hash_matcher_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    pshm_match_checker match_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .pending     (pending),
        .fail_count  (fail_count)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver back-pressure, redrawn every cycle
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #(64'd60_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    // One element beat, with random idle cycles in front; called at a falling edge
    task automatic send_item(input logic [31:0] value, input logic first);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Wait until every predicted result has come back, then let the block settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_target(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        cur_target  = value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Element values: mostly small (duplicates, pairs), some full range and extremes
    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(19);
        if (sel < 8)
            return 32'($signed($urandom_range(32)) - 16);
        else if (sel < 15)
            return $urandom;
        else if (sel < 17) begin
            case ($urandom_range(3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return 32'($signed($urandom_range(4000)) - 2000);
    endfunction

    // Short arrays, most with a planted pair; a few long ones and a few missing start marks
    task automatic run_random_arrays(input int budget);
        logic [31:0] elems [40];
        int          len;
        int          sent;
        int          i;
        int          j;
        longint      partner;
        sent = 0;
        while (sent < budget) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(40, 8) : $urandom_range(6, 1);
            for (int k = 0; k < len; k++)
                elems[k] = pick_value();
            if (len > 1 && $urandom_range(9) < 7) begin
                i = $urandom_range(len - 2);
                j = $urandom_range(len - 1, i + 1);
                partner = longint'($signed(cur_target)) - longint'($signed(elems[i]));
                if (partner >= -(64'sd1 <<< 31) && partner < (64'sd1 <<< 31))
                    elems[j] = partner[31:0];
            end
            for (int k = 0; k < len; k++)
                send_item(elems[k], (k == 0) ? ($urandom_range(19) != 0) : 1'b0);
            sent += len;
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cur_target     = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Array begun by reset, no start mark; reset target of zero
        send_item(32'd5, 1'b0);
        send_item(-32'sd5, 1'b0);
        send_item(32'd7, 1'b0);
        // Extremes, complement out of range, then a hit on the largest value
        send_item(32'h7FFF_FFFF, 1'b1);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h8000_0001, 1'b0);
        // Duplicate keeps the latest index
        send_item(32'd3, 1'b1);
        send_item(32'd3, 1'b0);
        send_item(32'd3, 1'b0);
        send_item(-32'sd3, 1'b0);
        // Value paired with itself, then single-element arrays
        send_item(32'd0, 1'b1);
        send_item(32'd0, 1'b0);
        send_item(32'd9, 1'b1);
        send_item(-32'sd9, 1'b1);
        drain_results();

        write_target(32'h7FFF_FFFF);
        send_item(32'hFFFF_FFFF, 1'b1);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'd0, 1'b0);
        drain_results();

        write_target(32'h8000_0000);
        send_item(32'd1, 1'b1);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'd0, 1'b0);
        drain_results();

        // Fill every slot with no pair possible, then miss, overwrite and hit on a full table
        write_target(32'h7FFF_FFFF);
        for (int k = 0; k < pshm_pkg::TableSize; k++)
            send_item(32'(k), k == 0);
        send_item(32'd5000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'd5, 1'b0);
        send_item(32'h7FFF_FFFA, 1'b0);
        send_item(32'd9, 1'b0);
        drain_results();

        // Random arrays under each idling pattern, a fresh target per phase
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_target($urandom);
                1: write_target(32'($signed($urandom_range(64)) - 32));
                2: write_target(32'hFFFF_FFFF);
                default: write_target($urandom);
            endcase
            send_idle_pct  = (phase == 1) ? 73 : (phase == 3) ? 38 : 0;
            recv_stall_pct = (phase == 2) ? 73 : (phase == 3) ? 38 : 0;
            run_random_arrays(300);
            drain_results();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end

        repeat (50) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
